@@ sv/cbad_pkg.sv @@
`timescale 1ns / 1ps

package cbad_pkg;

  // Default sizes of the decoded targets, in bytes
  localparam int unsigned RamBytesDef     = 32'd2097152;
  localparam int unsigned BiosBytesDef    = 32'd524288;
  localparam int unsigned ScratchBytesDef = 32'd1024;

  // Access kind
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Access size codes
  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;

  // Top address bits of the segments that map memory
  localparam logic [2:0] SegUser     = 3'd0;
  localparam logic [2:0] SegCached   = 3'd4;
  localparam logic [2:0] SegUncached = 3'd5;

  // Physical 64 KiB pages and regions
  localparam logic [12:0] PageIo    = 13'h1f80;
  localparam logic [12:0] PagePport = 13'h1f00;
  localparam logic [6:0]  BiosTop   = 7'h7f;   // phys[28:22] of 0x1fc00000

  // Cache control register and its command values
  localparam logic [31:0] CmdAddr    = 32'hfffe0130;
  localparam logic [31:0] IsoOnA     = 32'h0000_0800;
  localparam logic [31:0] IsoOnB     = 32'h0000_0804;
  localparam logic [31:0] IsoOffA    = 32'h0000_0000;
  localparam logic [31:0] IsoOffB    = 32'h0001_e988;

  typedef enum logic [2:0] {
    TgtNone    = 3'd0,
    TgtRam     = 3'd1,
    TgtPport   = 3'd2,
    TgtScratch = 3'd3,
    TgtHwreg   = 3'd4,
    TgtBios    = 3'd5
  } tgt_e;

  typedef struct packed {
    logic        op;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_value;
  } acc_req_t;

  typedef struct packed {
    tgt_e        target;
    logic [20:0] target_offset;
    logic        write_enable;
    logic        read_zero;
    logic        icache_invalidate;
    logic        cycle_charge;
    logic        isolated_now;
  } acc_rsp_t;

endpackage

@@ sv/console_bus_address_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                          Moves
// in        input      in_valid_i/in_ready_o/in_data_i  one bus access per transfer
// out       output     out_valid_o/out_ready_i/out_data_o  one decode result per transfer
// cfg       input      cfg_we_i/cfg_wdata_i             timing_hack bit, no wait
//
// One access per cycle sustained while results are taken; each access passes the input
// register, then the result register, with the single decode pass between them.
// The RAM mirror offset uses a seven-step constant compare-subtract chain.
// rst_ni clears the valid flags, timing_hack and the RAM isolation bit.
// A stalled result holds in the output register; the input register keeps
// taking transfers as long as the result can move on.
module console_bus_address_decoder
  import cbad_pkg::*;
#(
  parameter int unsigned RAM_BYTES     = RamBytesDef,
  parameter int unsigned BIOS_BYTES    = BiosBytesDef,
  parameter int unsigned SCRATCH_BYTES = ScratchBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  acc_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output acc_rsp_t out_data_o
);

  logic     s1_valid_q, s1_valid_d;
  acc_req_t s1_data_q;
  logic     out_valid_q, out_valid_d;
  acc_rsp_t out_data_q, out_data_d;
  logic     timing_hack_q, timing_hack_d;
  logic     ram_isolated_q, ram_isolated_d;
  logic     advance;

  logic [2:0]  seg;
  logic [28:0] phys;
  logic [15:0] low;
  logic        seg_ok;
  logic [22:0] ram_rem;
  logic        is_cmd;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  assign seg    = s1_data_q.address[31:29];
  assign phys   = s1_data_q.address[28:0];
  assign low    = s1_data_q.address[15:0];
  assign seg_ok = (seg == SegUser) || (seg == SegCached) || (seg == SegUncached);
  assign is_cmd = (s1_data_q.address == CmdAddr) && s1_data_q.access_size[1];

  // Reduce the 8 MiB window offset modulo RAM_BYTES, largest multiple first
  always_comb begin
    ram_rem = phys[22:0];
    for (int k = 6; k >= 0; k--) begin
      if ((30'(RAM_BYTES) << k) <= {7'd0, ram_rem}) begin
        ram_rem = ram_rem - 23'(30'(RAM_BYTES) << k);
      end
    end
  end

  always_comb begin
    out_data_d     = '0;
    ram_isolated_d = ram_isolated_q;

    if (seg_ok) begin
      if (phys[28:23] == 6'd0) begin
        out_data_d.target        = TgtRam;
        out_data_d.target_offset = ram_rem[20:0];
      end else if (phys[28:16] == PageIo) begin
        out_data_d.target        = ({1'b0, low} < 17'(SCRATCH_BYTES)) ? TgtScratch : TgtHwreg;
        out_data_d.target_offset = {5'd0, low};
      end else if ((seg == SegUser) && (phys[28:16] == PagePport)) begin
        out_data_d.target        = TgtPport;
        out_data_d.target_offset = {5'd0, low};
      end else if ((phys[28:22] == BiosTop) && (phys[21:0] < 22'(BIOS_BYTES))) begin
        out_data_d.target        = TgtBios;
        out_data_d.target_offset = phys[20:0];
      end
    end

    if (s1_data_q.op == OpWrite) begin
      unique case (out_data_d.target)
        TgtRam:                        out_data_d.write_enable = !ram_isolated_q;
        TgtPport, TgtScratch, TgtHwreg: out_data_d.write_enable = 1'b1;
        TgtNone: begin
          if (is_cmd) begin
            if ((s1_data_q.write_value == IsoOnA) || (s1_data_q.write_value == IsoOnB)) begin
              ram_isolated_d                = 1'b1;
              out_data_d.icache_invalidate  = !ram_isolated_q;
            end else if ((s1_data_q.write_value == IsoOffA) ||
                         (s1_data_q.write_value == IsoOffB)) begin
              ram_isolated_d = 1'b0;
            end
          end
        end
        default:                       out_data_d.write_enable = 1'b0;
      endcase
    end else begin
      out_data_d.read_zero = (out_data_d.target == TgtNone);
    end

    out_data_d.cycle_charge = !(timing_hack_q ||
                                ((s1_data_q.op == OpRead) && (s1_data_q.access_size == SizeByte)));
    out_data_d.isolated_now = ram_isolated_d;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    timing_hack_d = cfg_we_i ? cfg_wdata_i : timing_hack_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      timing_hack_q  <= 1'b0;
      ram_isolated_q <= 1'b0;
    end else begin
      s1_valid_q    <= s1_valid_d;
      out_valid_q   <= out_valid_d;
      timing_hack_q <= timing_hack_d;
      if (advance) begin
        ram_isolated_q <= ram_isolated_d;
      end
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ sv/cbad_checker.sv @@
`timescale 1ns / 1ps

module cbad_checker
  import cbad_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     cfg_we_i,
  input logic     cfg_wdata_i,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input acc_req_t in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input acc_rsp_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_none_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.target == TgtNone) |-> (out_data_o.target_offset == 21'd0))
    else $error("offset given for unmapped access");

  a_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.icache_invalidate |->
      out_data_o.isolated_now && (out_data_o.target == TgtNone) && !out_data_o.write_enable)
    else $error("invalidate without isolation command");

  a_we_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_enable |->
      (out_data_o.target != TgtNone) && (out_data_o.target != TgtBios) && !out_data_o.read_zero)
    else $error("write enabled to a read-only or missing target");

endmodule

bind console_bus_address_decoder cbad_checker u_cbad_checker (.*);
